[hw/rtl/bopp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bopp_pkg
// Shared types and constants of the OPEN message parser: record layout,
// record kinds, status codes and protocol constants.
// ----------------------------------------------------------------------------
package bopp_pkg;

    // header is version, AS, hold time, identifier and parameter length
    localparam logic [8:0] HDR_LEN        = 9'd10;
    localparam logic [7:0] CAP_PARAM_TYPE = 8'd2;
    localparam logic [7:0] FIXED_CAP_LEN  = 8'd4;

    localparam logic [7:0] CODE_MP      = 8'd1;
    localparam logic [7:0] CODE_AS4     = 8'd65;
    localparam logic [7:0] CODE_ADDPATH = 8'd69;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_AS4     = 3'd1;
    localparam logic [2:0] KIND_MP      = 3'd2;
    localparam logic [2:0] KIND_ADDPATH = 3'd3;
    localparam logic [2:0] KIND_OTHER   = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INVALID    = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [7:0]  version;
        logic [31:0] peer_as;
        logic [15:0] hold_seconds;
        logic [31:0] router_id;
        logic [7:0]  capability;
        logic [15:0] afi;
        logic [7:0]  safi;
        logic [7:0]  send_receive;
        logic [1:0]  status;
        logic [8:0]  bytes_read;
        logic        last;
    } rec_t;

    // records produced by one byte, in order: rec0 first
    typedef struct packed {
        logic [1:0] cnt;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

endpackage

[hw/rtl/bopp_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bopp_decoder
// Per-byte parse state machine. Updates the message state on every accepted
// byte and produces the zero, one or two records that the byte causes.
// ----------------------------------------------------------------------------
module bopp_decoder (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic [7:0]      in_byte,
    input  logic            in_final,
    output bopp_pkg::push_t push
);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_PTYPE,
        PH_PLEN,
        PH_PSKIP,
        PH_CCODE,
        PH_CLEN,
        PH_CVAL,
        PH_DRAIN
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [63:0] hdr_cap_reg, hdr_cap_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  window_reg, window_next;
    logic [7:0]  param_reg, param_next;
    logic [7:0]  cap_reg, cap_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  len_reg, len_next;
    logic [31:0] value_reg, value_next;

    logic           mid_valid;
    bopp_pkg::rec_t mid_rec;
    logic           end_valid;
    bopp_pkg::rec_t end_rec;
    logic [1:0]     end_status;
    logic           clear;

    always_comb begin
        logic       done;
        logic [7:0] pos;
        logic       known;

        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        hdr_cap_next    = hdr_cap_reg;
        version_next    = version_reg;
        window_next     = window_reg;
        param_next      = param_reg;
        cap_next        = cap_reg;
        code_next       = code_reg;
        len_next        = len_reg;
        value_next      = value_reg;
        mid_valid       = 1'b0;
        mid_rec         = '0;
        end_valid       = 1'b0;
        end_status      = bopp_pkg::ST_OK;
        clear           = 1'b0;
        done            = 1'b0;
        pos             = len_reg - cap_reg;
        known           = (code_reg == bopp_pkg::CODE_AS4) || (code_reg == bopp_pkg::CODE_MP)
                          || (code_reg == bopp_pkg::CODE_ADDPATH);

        if (phase_reg == PH_DRAIN) begin
            clear = in_final;
        end else if (phase_reg == PH_HDR) begin
            byte_count_next = byte_count_reg + 9'd1;
            if (byte_count_reg == 9'd0) begin
                version_next = in_byte;
            end else if (byte_count_reg < bopp_pkg::HDR_LEN - 9'd1) begin
                hdr_cap_next = {hdr_cap_reg[55:0], in_byte};
            end else begin
                mid_valid            = 1'b1;
                mid_rec.record_kind  = bopp_pkg::KIND_HEADER;
                mid_rec.version      = version_reg;
                mid_rec.peer_as      = {16'd0, hdr_cap_reg[63:48]};
                mid_rec.hold_seconds = hdr_cap_reg[47:32];
                mid_rec.router_id    = hdr_cap_reg[31:0];
                if (in_byte == 8'd0 || in_final) begin
                    end_valid = 1'b1;
                end else begin
                    window_next = in_byte;
                    phase_next  = PH_PTYPE;
                end
            end
            if (byte_count_reg < bopp_pkg::HDR_LEN - 9'd1 && in_final) begin
                end_valid  = 1'b1;
                end_status = bopp_pkg::ST_INCOMPLETE;
            end
        end else begin
            byte_count_next = byte_count_reg + 9'd1;
            window_next     = window_reg - 8'd1;
            case (phase_reg)
                PH_PTYPE: begin
                    if (in_byte != bopp_pkg::CAP_PARAM_TYPE) begin
                        end_valid  = 1'b1;
                        end_status = bopp_pkg::ST_INVALID;
                        done       = 1'b1;
                    end else begin
                        phase_next = PH_PLEN;
                    end
                end
                PH_PLEN: begin
                    param_next = in_byte;
                    if (in_byte >= 8'd2 && in_byte <= window_next) begin
                        phase_next = PH_CCODE;
                    end else if (in_byte == 8'd0) begin
                        phase_next = PH_PTYPE;
                    end else begin
                        phase_next = PH_PSKIP;
                    end
                end
                PH_PSKIP: begin
                    param_next = param_reg - 8'd1;
                    if (param_next == 8'd0) begin
                        phase_next = PH_PTYPE;
                    end
                end
                PH_CCODE: begin
                    code_next  = in_byte;
                    param_next = param_reg - 8'd1;
                    phase_next = (param_next != 8'd0) ? PH_CLEN : PH_PTYPE;
                end
                PH_CLEN: begin
                    len_next   = in_byte;
                    cap_next   = in_byte;
                    value_next = '0;
                    param_next = param_reg - 8'd1;
                    if ((code_reg == bopp_pkg::CODE_AS4 || code_reg == bopp_pkg::CODE_MP)
                        && in_byte != bopp_pkg::FIXED_CAP_LEN) begin
                        end_valid  = 1'b1;
                        end_status = bopp_pkg::ST_INVALID;
                        done       = 1'b1;
                    end else begin
                        if (!known) begin
                            mid_valid           = 1'b1;
                            mid_rec.record_kind = bopp_pkg::KIND_OTHER;
                            mid_rec.capability  = code_reg;
                        end
                        if (param_next == 8'd0) begin
                            phase_next = PH_PTYPE;
                        end else begin
                            phase_next = (in_byte == 8'd0) ? PH_CCODE : PH_CVAL;
                        end
                    end
                end
                PH_CVAL: begin
                    value_next = {value_reg[23:0], in_byte};
                    cap_next   = cap_reg - 8'd1;
                    param_next = param_reg - 8'd1;
                    if (code_reg == bopp_pkg::CODE_AS4 && cap_next == 8'd0) begin
                        mid_valid           = 1'b1;
                        mid_rec.record_kind = bopp_pkg::KIND_AS4;
                        mid_rec.capability  = bopp_pkg::CODE_AS4;
                        mid_rec.peer_as     = value_next;
                    end else if (code_reg == bopp_pkg::CODE_MP && cap_next == 8'd0) begin
                        mid_valid           = 1'b1;
                        mid_rec.record_kind = bopp_pkg::KIND_MP;
                        mid_rec.capability  = bopp_pkg::CODE_MP;
                        mid_rec.afi         = value_next[31:16];
                        mid_rec.safi        = value_next[7:0];
                    end else if (code_reg == bopp_pkg::CODE_ADDPATH
                                 && len_reg >= bopp_pkg::FIXED_CAP_LEN
                                 && pos[1:0] == 2'd3) begin
                        // one record per complete afi/safi/send-receive tuple
                        mid_valid            = 1'b1;
                        mid_rec.record_kind  = bopp_pkg::KIND_ADDPATH;
                        mid_rec.capability   = bopp_pkg::CODE_ADDPATH;
                        mid_rec.afi          = value_next[31:16];
                        mid_rec.safi         = value_next[15:8];
                        mid_rec.send_receive = value_next[7:0];
                    end
                    if (param_next == 8'd0) begin
                        phase_next = PH_PTYPE;
                    end else if (cap_next == 8'd0) begin
                        phase_next = PH_CCODE;
                    end
                end
                default: begin
                    phase_next = PH_PTYPE;
                end
            endcase
            if (!done && (window_next == 8'd0 || in_final)) begin
                end_valid  = 1'b1;
                end_status = bopp_pkg::ST_OK;
            end
        end

        end_rec             = '0;
        end_rec.record_kind = bopp_pkg::KIND_END;
        end_rec.status      = end_status;
        end_rec.bytes_read  = (end_status == bopp_pkg::ST_OK) ? byte_count_next : 9'd0;

        if (end_valid) begin
            if (in_final) begin
                clear = 1'b1;
            end else begin
                phase_next = PH_DRAIN;
            end
        end

        // end of buffer starts the next message from scratch
        if (clear) begin
            phase_next      = PH_HDR;
            byte_count_next = '0;
            hdr_cap_next    = '0;
            version_next    = '0;
            window_next     = '0;
            param_next      = '0;
            cap_next        = '0;
            code_next       = '0;
            len_next        = '0;
            value_next      = '0;
        end
    end

    always_comb begin
        push      = '0;
        push.cnt  = in_fire ? ({1'b0, mid_valid} + {1'b0, end_valid}) : 2'd0;
        push.rec0 = mid_valid ? mid_rec : end_rec;
        push.rec0.last = !(mid_valid && end_valid);
        push.rec1 = end_rec;
        push.rec1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HDR;
            byte_count_reg <= '0;
            hdr_cap_reg    <= '0;
            version_reg    <= '0;
            window_reg     <= '0;
            param_reg      <= '0;
            cap_reg        <= '0;
            code_reg       <= '0;
            len_reg        <= '0;
            value_reg      <= '0;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            hdr_cap_reg    <= hdr_cap_next;
            version_reg    <= version_next;
            window_reg     <= window_next;
            param_reg      <= param_next;
            cap_reg        <= cap_next;
            code_reg       <= code_next;
            len_reg        <= len_next;
            value_reg      <= value_next;
        end
    end

endmodule

[hw/rtl/bopp_rec_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bopp_rec_queue
// Result queue: takes up to two records per cycle, hands out one per
// request on the result channel. Depth must be a power of two, at least two.
// ----------------------------------------------------------------------------
module bopp_rec_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  bopp_pkg::push_t push,
    output logic            space_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output bopp_pkg::rec_t  out_rec
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bopp_pkg::rec_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           pop;

    assign out_valid = (count_reg != '0);
    assign out_rec   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for the worst case of two records from the next byte
    assign space_ok  = (count_reg <= CW'(DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.cnt == 2'd2) begin
            entry_reg[wr_ptr_reg + PW'(1)] <= push.rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push.cnt);
            rd_ptr_reg <= rd_ptr_reg + PW'(pop);
            count_reg  <= count_reg + CW'(push.cnt) - CW'(pop);
        end
    end

endmodule

[hw/rtl/bgp_open_message_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_open_message_parser_unit
// Parses OPEN message bodies byte by byte into header, capability and end
// records.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one body byte per request, s_final_byte on the buffer's last
//   byte. m_ channel: one record per request, m_last on the last record that
//   a byte produced. every message ends with exactly one end record.
// a byte's records go into a QUEUE_DEPTH record queue when it is accepted.
// throughput: one byte per cycle while s_ready is high; a byte yields zero,
//   one or two records, drained one per cycle while m_ready is high.
// s_ready is high while the queue has room for two records, so a stalled
//   receiver holds off input before the queue can overflow; nothing is dropped.
// reset clears the parse state to the start of a header and empties the
//   queue; no records are pending after reset.
// bytes after an end record are discarded up to and including the byte
//   flagged final; the next byte starts a new message.
// ----------------------------------------------------------------------------
module bgp_open_message_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_record_kind,
    output logic [7:0]  m_version,
    output logic [31:0] m_peer_as,
    output logic [15:0] m_hold_seconds,
    output logic [31:0] m_router_id,
    output logic [7:0]  m_capability,
    output logic [15:0] m_afi,
    output logic [7:0]  m_safi,
    output logic [7:0]  m_send_receive,
    output logic [1:0]  m_status,
    output logic [8:0]  m_bytes_read,
    output logic        m_last
);

    bopp_pkg::push_t push;
    bopp_pkg::rec_t  out_rec;
    logic            in_fire;

    assign in_fire = s_valid && s_ready;

    bopp_decoder u_decoder (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_byte  (s_data_byte),
        .in_final (s_final_byte),
        .push     (push)
    );

    bopp_rec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rec   (out_rec)
    );

    assign m_record_kind  = out_rec.record_kind;
    assign m_version      = out_rec.version;
    assign m_peer_as      = out_rec.peer_as;
    assign m_hold_seconds = out_rec.hold_seconds;
    assign m_router_id    = out_rec.router_id;
    assign m_capability   = out_rec.capability;
    assign m_afi          = out_rec.afi;
    assign m_safi         = out_rec.safi;
    assign m_send_receive = out_rec.send_receive;
    assign m_status       = out_rec.status;
    assign m_bytes_read   = out_rec.bytes_read;
    assign m_last         = out_rec.last;

endmodule

[hw/rtl/bopp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bopp_checker
// Port-level checks of the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bopp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_record_kind,
    input logic [1:0] m_status,
    input logic [8:0] m_bytes_read,
    input logic       m_last
);

    // stalled record holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_record_kind)
            && $stable(m_status) && $stable(m_bytes_read) && $stable(m_last)))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_record_kind <= bopp_pkg::KIND_END))
        else $error("record kind out of range");

    // end record always closes the records of its byte
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_kind == bopp_pkg::KIND_END) |-> m_last)
        else $error("end record without last");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_record_kind != bopp_pkg::KIND_END
            || m_status != bopp_pkg::ST_OK)) |-> (m_bytes_read == 9'd0))
        else $error("byte count outside a good end record");

endmodule

bind bgp_open_message_parser_unit bopp_checker u_bopp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_record_kind (m_record_kind),
    .m_status      (m_status),
    .m_bytes_read  (m_bytes_read),
    .m_last        (m_last)
);
